// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/hctbp_pkg.sv -----
package hctbp_pkg;

    // Number of table entries.
    localparam int NUM_SYMBOLS = 256;
    localparam int SYM_AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    // Longest code that the table may hold.
    localparam logic [3:0] MAX_CODE_LEN = 4'd8;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

endpackage

// ----- rtl/core/huffman_code_table_bit_packer.sv -----
// Huffman encoder back end: a code table and an MSB-first byte packer. Load items write a
// table entry, encode items append the code of their symbol, and flush items emit any
// partial byte padded with zeros. The block takes one item per cycle, sustained, with no
// gap between items of any kind, as long as a held output byte does not stall it. The table
// entry is read into the read stage at the accepting edge, and the shift and merge with
// the pending bits load the output register as the read stage item leaves. The table
// lengths read as zero after reset through one valid bit per entry, so there is no
// clearing pass and the block is ready at once.
`include "assert_macros.svh"

module huffman_code_table_bit_packer
    import hctbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_symbol,
    input  logic [7:0] i_code_word,
    input  logic [3:0] i_code_len,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_from_flush
);

    // Code table: code word and saturated length per entry.
    logic [11:0]            r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_vld;

    // Read stage registers.
    logic       r_s1_v;
    logic [1:0] r_s1_op;
    logic       r_s1_ok;
    logic       r_rd_vld;
    logic [7:0] r_rd_word;
    logic [3:0] r_rd_len;

    // Packer state: pending bits right aligned.
    logic [6:0] r_pend_byte;
    logic [2:0] r_pend_bits;
    logic [6:0] n_pend_byte;
    logic [2:0] n_pend_bits;

    // Output register.
    logic       r_out_v;
    logic [7:0] r_out_byte;
    logic       r_out_flush;

    logic        in_acc;
    logic        sym_ok;
    logic [SYM_AW-1:0] sym_idx;
    logic [3:0]  load_len;
    logic        s1_res;
    logic        s1_adv;
    logic [7:0]  s1_byte;
    logic        s1_flush;
    logic [3:0]  s1_len;
    logic [7:0]  s1_code;
    logic [14:0] s1_acc;
    logic [3:0]  s1_total;
    logic [2:0]  s1_rest;

    // Input side handshake and address decode.
    assign sym_ok   = {1'b0, i_symbol} < 9'(NUM_SYMBOLS);
    assign sym_idx  = i_symbol[SYM_AW-1:0];
    assign load_len = (i_code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : i_code_len;
    assign s1_adv   = !s1_res || !r_out_v || i_out_ready;
    assign o_in_ready = !r_s1_v || s1_adv;
    assign in_acc   = i_in_valid && o_in_ready;

    // Table memory: one read per accepted item, plus one write for a load.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_op == OP_LOAD && sym_ok) begin
                r_mem[sym_idx] <= {i_code_word, load_len};
            end
            r_rd_word <= r_mem[sym_idx][11:4];
            r_rd_len  <= r_mem[sym_idx][3:0];
            r_rd_vld  <= r_vld[sym_idx];
            r_s1_op   <= i_op;
            r_s1_ok   <= sym_ok;
        end
    end

    // Entry valid bits and read stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (in_acc && i_op == OP_LOAD && sym_ok) begin
                r_vld[sym_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    // Shift and merge of the looked-up code with the pending bits.
    always_comb begin
        s1_len   = (r_rd_vld && r_s1_ok) ? r_rd_len : 4'd0;
        s1_code  = r_rd_word & 8'((9'd1 << s1_len) - 9'd1);
        s1_acc   = (15'(r_pend_byte) << s1_len) | 15'(s1_code);
        s1_total = {1'b0, r_pend_bits} + s1_len;
        s1_rest  = s1_total[2:0];
        s1_res   = 1'b0;
        s1_byte  = 8'd0;
        s1_flush = 1'b0;
        n_pend_byte = r_pend_byte;
        n_pend_bits = r_pend_bits;
        case (r_s1_op)
            OP_ENCODE: begin
                if (s1_len != 4'd0) begin
                    if (s1_total[3]) begin
                        s1_res      = 1'b1;
                        s1_byte     = 8'(s1_acc >> s1_rest);
                        n_pend_byte = 7'(s1_acc) & 7'((8'd1 << s1_rest) - 8'd1);
                        n_pend_bits = s1_rest;
                    end else begin
                        n_pend_byte = 7'(s1_acc);
                        n_pend_bits = s1_rest;
                    end
                end
            end
            OP_FLUSH: begin
                if (r_pend_bits != 3'd0) begin
                    s1_res      = 1'b1;
                    s1_flush    = 1'b1;
                    s1_byte     = 8'({1'b0, r_pend_byte} << (4'd8 - {1'b0, r_pend_bits}));
                    n_pend_byte = 7'd0;
                    n_pend_bits = 3'd0;
                end
            end
            default: begin
                s1_res = 1'b0;
            end
        endcase
    end

    // Pending state, updated as the read stage item leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_byte <= 7'd0;
            r_pend_bits <= 3'd0;
        end else if (r_s1_v && s1_adv) begin
            r_pend_byte <= n_pend_byte;
            r_pend_bits <= n_pend_bits;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (r_s1_v && s1_adv && s1_res) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && s1_adv && s1_res) begin
            r_out_byte  <= s1_byte;
            r_out_flush <= s1_flush;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_out_byte   = r_out_byte;
    assign o_from_flush = r_out_flush;

    // A stalled read stage item must still be there next cycle.
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_v && !s1_adv, r_s1_v, "read stage item lost")

    // A flush that emits a byte leaves nothing pending.
    `ASSERT_NEXT(a_flush_clear, i_clk, i_rst_n, r_s1_v && s1_adv && s1_flush, r_pend_bits == 3'd0 && r_pend_byte == 7'd0, "flush left bits pending")

    // No pending bit lies above the pending count.
    `ASSERT_SAME(a_pend_clean, i_clk, i_rst_n, 1'b1, (r_pend_byte >> r_pend_bits) == 7'd0, "stray pending bits")

endmodule

// ----- tb/huffman_code_table_bit_packer_test.sv -----
module huffman_code_table_bit_packer_test
    import hctbp_pkg::*;
();

    // The op value that has no operation behind it; the block must ignore it.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int TABLE_DEPTH    = 256;
    localparam int PHASE_ITEMS    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    // One packed output byte as it should leave the block.
    typedef struct {
        logic [7:0] out_byte;
        logic       from_flush;
    } t_packed_byte;

    // Scoreboard: keeps its own copy of the code table and the packer, and
    // queues the bytes that each accepted item should produce.
    class packer_scoreboard;
        logic [7:0]   code_words [TABLE_DEPTH];
        logic [3:0]   code_lengths [TABLE_DEPTH];
        logic [7:0]   pending_byte;
        logic [2:0]   pending_bits;
        t_packed_byte expected_bytes [$];
        int           errors;
        int           items_seen;
        int           bytes_checked;
        int           flush_bytes;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                code_words[i]   = 8'd0;
                code_lengths[i] = 4'd0;
            end
            pending_byte  = 8'd0;
            pending_bits  = 3'd0;
            errors        = 0;
            items_seen    = 0;
            bytes_checked = 0;
            flush_bytes   = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Work out what an accepted item does to the table and the packer.
        function void note_item(logic [1:0] op, logic [7:0] sym, logic [7:0] word,
                                logic [3:0] len);
            logic [15:0]  acc;
            int           n;
            int           total;
            int           rest;
            t_packed_byte next_byte;
            items_seen++;
            case (op)
                OP_LOAD: begin
                    code_words[sym]   = word;
                    code_lengths[sym] = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
                end
                OP_ENCODE: begin
                    n = code_lengths[sym];
                    // A zero-length code appends nothing.
                    if (n != 0) begin
                        acc   = ({8'd0, pending_byte} << n)
                              | ({8'd0, code_words[sym]} & ((16'd1 << n) - 16'd1));
                        total = pending_bits + n;
                        if (total >= 8) begin
                            rest                 = total - 8;
                            next_byte.out_byte   = 8'(acc >> rest);
                            next_byte.from_flush = 1'b0;
                            expected_bytes.push_back(next_byte);
                            pending_byte = 8'(acc & ((16'd1 << rest) - 16'd1));
                            pending_bits = 3'(rest);
                        end else begin
                            pending_byte = acc[7:0];
                            pending_bits = 3'(total);
                        end
                    end
                end
                OP_FLUSH: begin
                    // Only a partial byte is flushed; an empty packer gives nothing.
                    if (pending_bits != 3'd0) begin
                        next_byte.out_byte   = 8'(pending_byte << (8 - pending_bits));
                        next_byte.from_flush = 1'b1;
                        expected_bytes.push_back(next_byte);
                        pending_byte = 8'd0;
                        pending_bits = 3'd0;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare an accepted output byte with the oldest expected one.
        function void check_result(logic [7:0] got_byte, logic got_flush);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, got out_byte %02h from_flush %0b",
                         $time, got_byte, got_flush);
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want.from_flush)
                flush_bytes++;
            if (got_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %02h, got %02h",
                         $time, want.out_byte, got_byte);
            end
            if (got_flush !== want.from_flush) begin
                errors++;
                $display("%0t: from_flush mismatch, expected %0b, got %0b",
                         $time, want.from_flush, got_flush);
            end
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_op         = OP_LOAD;
    logic [7:0] i_symbol     = 8'd0;
    logic [7:0] i_code_word  = 8'd0;
    logic [3:0] i_code_len   = 4'd0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_from_flush;

    packer_scoreboard sb;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               quiet_cycles   = 0;
    logic [7:0]       hot_syms [8];

    huffman_code_table_bit_packer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_symbol     (i_symbol),
        .i_code_word  (i_code_word),
        .i_code_len   (i_code_len),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_from_flush (o_from_flush)
    );

    // Clock with a period of 20.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge i_clk) begin
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both handshakes at the rising edge; the watchdog ends a hung run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_item(i_op, i_symbol, i_code_word, i_code_len);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_byte, o_from_flush);
        end
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one item, after a random idle gap, and hold it until accepted.
    // Called and left at a falling edge.
    task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [7:0] word,
                             logic [3:0] len);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_symbol    <= sym;
        i_code_word <= word;
        i_code_len  <= len;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected byte has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic encode(logic [7:0] sym);
        send_item(OP_ENCODE, sym, 8'($urandom), 4'($urandom));
    endtask

    // Table extremes, saturated lengths, ignored high bits, byte straddles,
    // flushes with and without pending bits and the reserved op.
    task automatic run_directed();
        encode(8'h00);
        send_item(OP_FLUSH, 8'h00, 8'h00, 4'd0);
        send_item(OP_RESERVED, 8'hFF, 8'hFF, 4'hF);
        send_item(OP_LOAD, 8'hFF, 8'hFF, 4'd8);
        send_item(OP_LOAD, 8'h00, 8'h00, 4'd0);
        send_item(OP_LOAD, 8'h01, 8'hA5, 4'hF);
        send_item(OP_LOAD, 8'h02, 8'hFF, 4'd3);
        send_item(OP_LOAD, 8'h03, 8'h01, 4'd1);
        send_item(OP_LOAD, 8'h80, 8'h55, 4'd9);
        encode(8'hFF);
        encode(8'h01);
        encode(8'h02);
        send_item(OP_FLUSH, 8'hFF, 8'hFF, 4'hF);
        encode(8'h00);
        for (int i = 0; i < 8; i++)
            encode(8'h03);
        encode(8'h02);
        encode(8'h80);
        encode(8'h02);
        encode(8'h03);
        send_item(OP_FLUSH, 8'h00, 8'h00, 4'd0);
        hot_syms = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h80, 8'hFF, 8'h02, 8'h03};
    endtask

    // Mostly encodes, often of recently loaded symbols, with fresh loads mixed in,
    // some flushes and the odd reserved op.
    task automatic send_random();
        int         pick;
        logic [7:0] sym;
        pick = $urandom_range(99);
        if ($urandom_range(1) == 0)
            sym = hot_syms[$urandom_range(7)];
        else
            sym = 8'($urandom_range(255));
        if (pick < 15) begin
            sym = 8'($urandom_range(255));
            send_item(OP_LOAD, sym, 8'($urandom), 4'($urandom_range(15)));
            hot_syms[$urandom_range(7)] = sym;
        end else if (pick < 88) begin
            encode(sym);
        end else if (pick < 97) begin
            send_item(OP_FLUSH, sym, 8'($urandom), 4'($urandom));
        end else begin
            send_item(OP_RESERVED, sym, 8'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        wait_drained();

        // Phases: no idling, a slow sender, a slow receiver, then both a little.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            repeat (PHASE_ITEMS) send_random();
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
        end

        $display("Sent %0d items (loads, encodes, flushes, reserved ops) over four phases.",
                 sb.items_seen);
        $display("Checked %0d packed bytes, %0d of them zero-padded flushes; %0d errors.",
                 sb.bytes_checked, sb.flush_bytes, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hctbp_pkg.sv
rtl/core/huffman_code_table_bit_packer.sv
tb/huffman_code_table_bit_packer_test.sv
